FILE: design/kst_pkg.sv
// Package for the key set table: sizes, codes, shared types and key compare.
`timescale 1ns / 1ps

package kst_pkg;

   localparam int SET_SIZE      = 16;
   localparam int IDX_W         = (SET_SIZE > 1) ? $clog2(SET_SIZE) : 1;
   localparam int COUNT_W       = $clog2(SET_SIZE + 1);
   localparam int KEY_W         = 64;
   localparam int MODE_W        = 2;
   localparam int STATUS_W      = 3;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SET_SIZE - 1);

   localparam logic [MODE_W-1:0] MODE_INSERT        = 2'd0;
   localparam logic [MODE_W-1:0] MODE_INSERT_ABSENT = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REMOVE        = 2'd2;
   localparam logic [MODE_W-1:0] MODE_QUERY         = 2'd3;

   localparam logic [STATUS_W-1:0] STATUS_INSERTED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_PRESENT    = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_REMOVED    = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_MEMBER = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY      = 3'd4;
   localparam logic [STATUS_W-1:0] STATUS_FULL       = 3'd5;
   localparam logic [STATUS_W-1:0] STATUS_MEMBER     = 3'd6;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic scan_done;
      logic rsp_hold;
   } sts_type;

   function automatic logic is_nan(input logic [KEY_W-1:0] v);
      is_nan = (v[62:52] == 11'h7FF) && (v[51:0] != 52'd0);
   endfunction

   function automatic logic keys_equal(input logic [KEY_W-1:0] a,
                                       input logic [KEY_W-1:0] b);
      if (is_nan(a) || is_nan(b)) begin
         keys_equal = 1'b0;
      end else if ((a[62:0] == 63'd0) && (b[62:0] == 63'd0)) begin
         keys_equal = 1'b1;
      end else begin
         keys_equal = (a == b);
      end
   endfunction

endpackage

FILE: design/kst_ctrl.sv
// Controller state machine for the key set table.
`timescale 1ns / 1ps

module kst_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  kst_pkg::sts_type sts,
   output kst_pkg::cmd_type cmd
);

   kst_pkg::state_type state_ff;
   kst_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= kst_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kst_pkg::ST_IDLE: begin
            if (req_valid) state_in = kst_pkg::ST_SCAN;
         end
         kst_pkg::ST_SCAN: begin
            if (sts.scan_done) state_in = kst_pkg::ST_FINISH;
         end
         kst_pkg::ST_FINISH: begin
            if (!sts.rsp_hold) state_in = kst_pkg::ST_IDLE;
         end
         default: state_in = kst_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_stall  = 1'b1;
      cmd.start  = 1'b0;
      cmd.scan   = 1'b0;
      cmd.finish = 1'b0;
      unique case (state_ff)
         kst_pkg::ST_IDLE: begin
            req_stall = reset;
            cmd.start = req_valid && !reset;
         end
         kst_pkg::ST_SCAN: begin
            cmd.scan = 1'b1;
         end
         kst_pkg::ST_FINISH: begin
            cmd.finish = !sts.rsp_hold;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

FILE: design/kst_datapath.sv
// Datapath for the key set table: key memory, valid marks, scan and result register.
`timescale 1ns / 1ps

module kst_datapath (
   input  logic                                 clock,
   input  logic                                 reset,
   input  kst_pkg::cmd_type                     cmd,
   output kst_pkg::sts_type                     sts,
   input  logic [kst_pkg::MODE_W-1:0]           req_mode,
   input  logic [kst_pkg::KEY_W-1:0]            req_key,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [kst_pkg::STATUS_W-1:0]         rsp_status,
   output logic [kst_pkg::ENTRY_COUNT_W-1:0]    rsp_entry_count
);

   logic [kst_pkg::KEY_W-1:0]   key_mem [kst_pkg::SET_SIZE];
   logic [kst_pkg::SET_SIZE-1:0] valid_ff;
   logic [kst_pkg::COUNT_W-1:0] count_ff;

   logic [kst_pkg::MODE_W-1:0]  mode_ff;
   logic [kst_pkg::KEY_W-1:0]   key_ff;
   logic [kst_pkg::IDX_W-1:0]   issue_idx_ff;
   logic                        issue_live_ff;
   logic [kst_pkg::KEY_W-1:0]   rd_data_ff;
   logic [kst_pkg::IDX_W-1:0]   cmp_idx_ff;
   logic                        cmp_live_ff;
   logic                        found_ff;
   logic [kst_pkg::IDX_W-1:0]   found_idx_ff;
   logic                        free_found_ff;
   logic [kst_pkg::IDX_W-1:0]   free_idx_ff;

   logic                        rsp_valid_ff;
   logic [kst_pkg::STATUS_W-1:0] rsp_status_ff;
   logic [kst_pkg::ENTRY_COUNT_W-1:0] rsp_count_ff;

   logic                        match;
   logic [kst_pkg::STATUS_W-1:0] status_in;
   logic                        do_insert;
   logic                        do_remove;
   logic [kst_pkg::COUNT_W-1:0] count_in;

   localparam logic [kst_pkg::COUNT_W-1:0] COUNT_ONE = kst_pkg::COUNT_W'(1);

   assign match = cmp_live_ff && valid_ff[cmp_idx_ff]
                  && kst_pkg::keys_equal(rd_data_ff, key_ff);

   assign sts.scan_done = cmp_live_ff && (cmp_idx_ff == kst_pkg::LAST_IDX);
   assign sts.rsp_hold  = rsp_valid_ff && rsp_stall;

   always_comb begin
      status_in = kst_pkg::STATUS_NOT_MEMBER;
      do_insert = 1'b0;
      do_remove = 1'b0;
      case (mode_ff)
         kst_pkg::MODE_INSERT: begin
            do_insert = free_found_ff;
            status_in = free_found_ff ? kst_pkg::STATUS_INSERTED : kst_pkg::STATUS_FULL;
         end
         kst_pkg::MODE_INSERT_ABSENT: begin
            if (found_ff) begin
               status_in = kst_pkg::STATUS_PRESENT;
            end else begin
               do_insert = free_found_ff;
               status_in = free_found_ff ? kst_pkg::STATUS_INSERTED
                                         : kst_pkg::STATUS_FULL;
            end
         end
         kst_pkg::MODE_REMOVE: begin
            if (count_ff == '0) begin
               status_in = kst_pkg::STATUS_EMPTY;
            end else if (found_ff) begin
               do_remove = 1'b1;
               status_in = kst_pkg::STATUS_REMOVED;
            end else begin
               status_in = kst_pkg::STATUS_NOT_MEMBER;
            end
         end
         default: begin
            status_in = found_ff ? kst_pkg::STATUS_MEMBER : kst_pkg::STATUS_NOT_MEMBER;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      if (do_insert) count_in = count_ff + COUNT_ONE;
      else if (do_remove) count_in = count_ff - COUNT_ONE;
   end

   // key memory: one read port for the scan, one write port at finish
   always_ff @(posedge clock) begin
      if (cmd.scan && issue_live_ff) rd_data_ff <= key_mem[issue_idx_ff];
      if (cmd.finish && do_insert) key_mem[free_idx_ff] <= key_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.start) begin
         mode_ff <= req_mode;
         key_ff  <= req_key;
      end
      if (cmd.scan && issue_live_ff) cmp_idx_ff <= issue_idx_ff;
      if (cmd.scan && match && !found_ff) found_idx_ff <= cmp_idx_ff;
      if (cmd.scan && issue_live_ff && !valid_ff[issue_idx_ff] && !free_found_ff) begin
         free_idx_ff <= issue_idx_ff;
      end
      if (cmd.finish) begin
         rsp_status_ff <= status_in;
         rsp_count_ff  <= kst_pkg::ENTRY_COUNT_W'(count_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         count_ff      <= '0;
         issue_idx_ff  <= '0;
         issue_live_ff <= 1'b0;
         cmp_live_ff   <= 1'b0;
         found_ff      <= 1'b0;
         free_found_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.start) begin
            issue_idx_ff  <= '0;
            issue_live_ff <= 1'b1;
            cmp_live_ff   <= 1'b0;
            found_ff      <= 1'b0;
            free_found_ff <= 1'b0;
         end else if (cmd.scan) begin
            cmp_live_ff <= issue_live_ff;
            if (issue_live_ff) begin
               if (issue_idx_ff == kst_pkg::LAST_IDX) issue_live_ff <= 1'b0;
               else issue_idx_ff <= issue_idx_ff + kst_pkg::IDX_W'(1);
               if (!valid_ff[issue_idx_ff]) free_found_ff <= 1'b1;
            end
            if (match) found_ff <= 1'b1;
         end
         if (cmd.finish) begin
            count_ff <= count_in;
            if (do_insert) valid_ff[free_idx_ff] <= 1'b1;
            if (do_remove) valid_ff[found_idx_ff] <= 1'b0;
         end
         if (cmd.finish) rsp_valid_ff <= 1'b1;
         else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

   a_count_matches_marks: assert property (@(posedge clock) disable iff (reset)
      count_ff == kst_pkg::COUNT_W'($countones(valid_ff)))
      else $error("occupancy differs from number of valid marks");

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= kst_pkg::COUNT_W'(kst_pkg::SET_SIZE))
      else $error("occupancy above table size");

   a_insert_marks: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && do_insert) |=> valid_ff[$past(free_idx_ff)])
      else $error("inserted entry not marked valid");

   a_remove_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && do_remove) |=> !valid_ff[$past(found_idx_ff)])
      else $error("removed entry still marked valid");

endmodule

FILE: design/key_set_table.sv
// Top level of the key set table: controller plus datapath.
//
//   channel   direction   handshake              payload
//   req       in          req_valid / req_stall  req_mode[1:0], req_key[63:0]
//   rsp       out         rsp_valid / rsp_stall  rsp_status[2:0], rsp_entry_count[4:0]
//
// Each item is accepted, then the key memory is walked through its single registered read
// port, then the table is updated and the response is given.
// Reset is synchronous and clears all valid marks at once; no clearing pass is needed.
// A waiting result does not block the next item; only a second result held by rsp_stall
// holds the block in its final step.
`timescale 1ns / 1ps

module key_set_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kst_pkg::MODE_W-1:0]        req_mode,
   input  logic [kst_pkg::KEY_W-1:0]         req_key,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kst_pkg::STATUS_W-1:0]      rsp_status,
   output logic [kst_pkg::ENTRY_COUNT_W-1:0] rsp_entry_count
);

   kst_pkg::cmd_type cmd;
   kst_pkg::sts_type sts;

   kst_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   kst_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_mode        (req_mode),
      .req_key         (req_key),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_entry_count (rsp_entry_count)
   );

endmodule
